// ===== sv/tile_dirty_rect_detect_macros.svh =====
// assertion macros shared by the dirty rectangle detector modules
`ifndef TILE_DIRTY_RECT_DETECT_MACROS_SVH
`define TILE_DIRTY_RECT_DETECT_MACROS_SVH

// checked only while out of reset
`define TDR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// checked at every edge, reset included
`define TDR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) (expr)) \
        else $error(msg);

`endif

// ===== sv/tdr_pkg.sv =====
// shared constants, types and helpers of the dirty rectangle detector
package tdr_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int TILE_SIZE  = 16;
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int TILE_SHIFT = $clog2(TILE_SIZE);
    localparam int TILE_W     = POS_W - TILE_SHIFT;
    localparam int PIX_W      = 32;
    localparam int IDX_W      = 8;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } dims_t;

    // one classified pixel as handed from front to back
    typedef struct packed {
        logic              diff;
        logic [TILE_W-1:0] tx;
        logic [TILE_W-1:0] ty;
        logic              last;
    } rec_t;

    typedef struct packed {
        logic             changed;
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
    } result_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// ===== sv/tdr_front.sv =====
// front end: raster position tracking and per-pixel classification
module tdr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  tdr_pkg::dims_t      dims,
    input  logic                push,
    input  logic [tdr_pkg::PIX_W-1:0] pixel_a,
    input  logic [tdr_pkg::PIX_W-1:0] pixel_b,
    input  logic                q_full,
    output logic                q_push,
    output tdr_pkg::rec_t       q_data
);

    logic [tdr_pkg::POS_W-1:0] col_reg, col_next;
    logic [tdr_pkg::POS_W-1:0] row_reg, row_next;
    logic                      accept;
    logic                      col_last;
    logic                      row_last;

    assign accept   = push && !q_full;
    assign col_last = ({1'b0, col_reg} + tdr_pkg::DIM_W'(1)) >= dims.w;
    assign row_last = ({1'b0, row_reg} + tdr_pkg::DIM_W'(1)) >= dims.h;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + tdr_pkg::POS_W'(1);
            end
            else
            begin
                col_next = col_reg + tdr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign q_push       = accept;
    assign q_data.diff  = pixel_a != pixel_b;
    assign q_data.tx    = col_reg[tdr_pkg::POS_W-1:tdr_pkg::TILE_SHIFT];
    assign q_data.ty    = row_reg[tdr_pkg::POS_W-1:tdr_pkg::TILE_SHIFT];
    assign q_data.last  = col_last && row_last;

endmodule

// ===== sv/tdr_queue.sv =====
// short queue of classified pixels between front and back
`include "tile_dirty_rect_detect_macros.svh"

module tdr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tdr_pkg::rec_t wdata,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output tdr_pkg::rec_t rdata
);

    tdr_pkg::rec_t              q_reg [tdr_pkg::QDEPTH];
    logic [tdr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tdr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tdr_pkg::QCNT_W-1:0] count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign full    = count_reg == tdr_pkg::QCNT_W'(tdr_pkg::QDEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + tdr_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + tdr_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + tdr_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - tdr_pkg::QCNT_W'(1);
        end
    end

    `TDR_ASSERT_ALWAYS(a_count_bound, count_reg <= tdr_pkg::QCNT_W'(tdr_pkg::QDEPTH), "queue count above depth")
    `TDR_ASSERT(a_count_up, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + tdr_pkg::QCNT_W'(1)), "queue count did not grow on push")

endmodule

// ===== sv/tdr_back.sv =====
// back end: bounding box accumulation and result register
`include "tile_dirty_rect_detect_macros.svh"

module tdr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  tdr_pkg::dims_t   dims,
    input  logic             q_empty,
    input  tdr_pkg::rec_t    q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output tdr_pkg::result_t result
);

    logic                       any_diff_reg;
    logic [tdr_pkg::TILE_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic                       any_upd;
    logic [tdr_pkg::TILE_W-1:0] min_x_upd, max_x_upd, min_y_upd, max_y_upd;
    logic                       out_valid_reg;
    tdr_pkg::result_t           out_reg;
    tdr_pkg::result_t           res_calc;
    logic [tdr_pkg::DIM_W-1:0]  right_raw;
    logic [tdr_pkg::DIM_W-1:0]  bottom_raw;
    logic                       out_take;
    logic                       take;

    assign out_take = pop && out_valid_reg;
    // a frame end waits only while the result slot is still occupied
    assign take     = !q_empty && (!q_data.last || !out_valid_reg || out_take);
    assign q_pop    = take;

    always_comb
    begin
        any_upd   = any_diff_reg;
        min_x_upd = min_x_reg;
        max_x_upd = max_x_reg;
        min_y_upd = min_y_reg;
        max_y_upd = max_y_reg;
        if (q_data.diff)
        begin
            any_upd = 1'b1;
            if (!any_diff_reg)
            begin
                min_x_upd = q_data.tx;
                max_x_upd = q_data.tx;
                min_y_upd = q_data.ty;
                max_y_upd = q_data.ty;
            end
            else
            begin
                if (q_data.tx < min_x_reg) min_x_upd = q_data.tx;
                if (q_data.tx > max_x_reg) max_x_upd = q_data.tx;
                if (q_data.ty < min_y_reg) min_y_upd = q_data.ty;
                if (q_data.ty > max_y_reg) max_y_upd = q_data.ty;
            end
        end
    end

    assign right_raw  = {({1'b0, max_x_upd} + (tdr_pkg::TILE_W + 1)'(1)),
                         tdr_pkg::TILE_SHIFT'(0)};
    assign bottom_raw = {({1'b0, max_y_upd} + (tdr_pkg::TILE_W + 1)'(1)),
                         tdr_pkg::TILE_SHIFT'(0)};

    always_comb
    begin
        res_calc = '0;
        if (any_upd)
        begin
            res_calc.changed = 1'b1;
            res_calc.left    = {1'b0, min_x_upd, tdr_pkg::TILE_SHIFT'(0)};
            res_calc.top     = {1'b0, min_y_upd, tdr_pkg::TILE_SHIFT'(0)};
            res_calc.right   = (right_raw > dims.w) ? dims.w : right_raw;
            res_calc.bottom  = (bottom_raw > dims.h) ? dims.h : bottom_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_diff_reg  <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear || (take && q_data.last))
            begin
                any_diff_reg <= 1'b0;
                min_x_reg    <= '0;
                max_x_reg    <= '0;
                min_y_reg    <= '0;
                max_y_reg    <= '0;
            end
            else if (take)
            begin
                any_diff_reg <= any_upd;
                min_x_reg    <= min_x_upd;
                max_x_reg    <= max_x_upd;
                min_y_reg    <= min_y_upd;
                max_y_reg    <= max_y_upd;
            end
            if (take && q_data.last)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_data.last)
            out_reg <= res_calc;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `TDR_ASSERT(a_clean_frame, (take && q_data.last && !q_data.diff && !any_diff_reg) |=> (out_valid_reg && !out_reg.changed), "clean frame reported as changed")
    `TDR_ASSERT(a_rect_order, (out_valid_reg && out_reg.changed) |-> ((out_reg.left < out_reg.right) && (out_reg.top < out_reg.bottom)), "dirty rectangle is empty")
    `TDR_ASSERT(a_zero_rect, (out_valid_reg && !out_reg.changed) |-> ((out_reg.left == '0) && (out_reg.top == '0) && (out_reg.right == '0) && (out_reg.bottom == '0)), "unchanged result carries a rectangle")

endmodule

// ===== sv/tile_dirty_rect_detect.sv =====
// top level of the tile dirty rectangle detector
//
// usage:
//   pixel pairs of two frames enter in raster order through push/full, one per
//   clock while full is low; the block counts column and row itself.
//   each pixel pair is classified in the front end and queued (4 deep) for the
//   back end, which grows the bounding box of dirty 16x16 tiles.
//   after the last pixel of a frame one result appears on the result ports;
//   empty falls once that pixel's record has been written into the queue and
//   then taken by the back end into the result register.
//   the result is held until popped; meanwhile pixels of the next frame keep
//   flowing. only if the next frame end arrives while a result still waits
//   does the back end stall, then the queue fills and full rises.
//   throughput: one pixel per cycle while full is low, as the bounding box update is combinational.
//   configuration: cfg_index 0 = frame_width, 1 = frame_height; a write restarts
//   the frame and must only be issued while the block is idle. cfg_ready is
//   always high; other indexes are ignored.
//   reset: dimensions return to 1920x1080, position and box are cleared,
//   queue and result slot are emptied.
module tile_dirty_rect_detect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tdr_pkg::PIX_W-1:0]         pixel_a,
    input  logic [tdr_pkg::PIX_W-1:0]         pixel_b,
    input  logic                              pop,
    output logic                              empty,
    output logic                              changed,
    output logic [tdr_pkg::DIM_W-1:0]         rect_left,
    output logic [tdr_pkg::DIM_W-1:0]         rect_top,
    output logic [tdr_pkg::DIM_W-1:0]         rect_right,
    output logic [tdr_pkg::DIM_W-1:0]         rect_bottom,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdr_pkg::IDX_W-1:0]         cfg_index,
    input  logic [tdr_pkg::DIM_W-1:0]         cfg_data
);

    logic [tdr_pkg::DIM_W-1:0] width_reg;
    logic [tdr_pkg::DIM_W-1:0] height_reg;
    logic                      clear;
    tdr_pkg::dims_t            dims;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    tdr_pkg::rec_t             q_wdata;
    tdr_pkg::rec_t             q_rdata;
    tdr_pkg::result_t          result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        clear = 1'b0;
        unique case (cfg_index)
            tdr_pkg::REG_FRAME_WIDTH:  clear = cfg_valid;
            tdr_pkg::REG_FRAME_HEIGHT: clear = cfg_valid;
            default:                   clear = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tdr_pkg::WIDTH_RESET;
            height_reg <= tdr_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tdr_pkg::REG_FRAME_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == tdr_pkg::REG_FRAME_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    assign dims.w = tdr_pkg::eff_dim(width_reg);
    assign dims.h = tdr_pkg::eff_dim(height_reg);

    tdr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .dims    (dims),
        .push    (push),
        .pixel_a (pixel_a),
        .pixel_b (pixel_b),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    tdr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    tdr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .dims    (dims),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full        = q_full;
    assign changed     = result.changed;
    assign rect_left   = result.left;
    assign rect_top    = result.top;
    assign rect_right  = result.right;
    assign rect_bottom = result.bottom;

endmodule
